// ===== sv/ota_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ota_pkg
// Types and constants shared by the overlap track associator.
// ----------------------------------------------------------------------------
package ota_pkg;

  typedef struct packed {
    logic [23:0]        frame_no;
    logic [7:0]         class_id;
    logic signed [15:0] box_x;
    logic signed [15:0] box_y;
    logic [14:0]        box_width;
    logic [14:0]        box_height;
    logic [15:0]        confidence_q16;
  } det_t;

  typedef struct packed {
    logic [15:0] track_id;
    logic [1:0]  status;
    logic [15:0] track_confidence_q16;
  } res_t;

  localparam logic [1:0] ST_EXTENDED = 2'd0;
  localparam logic [1:0] ST_NEW      = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  localparam logic signed [18:0] MIN_OVERLAP_RESET = 19'sd32768;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_GEOM, S_AREA, S_CMP, S_WRITE
  } ctl_state_t;

  typedef struct packed {
    logic load;     // capture detection, clear scan state
    logic rd;       // issue memory read of current slot
    logic geom;     // compute box geometry
    logic area;     // multiply areas
    logic cmp;      // compare and update best / free
    logic step;     // advance slot index
    logic commit;   // write back and emit result
  } dp_cmd_t;

  typedef struct packed {
    logic last_slot;
  } dp_sts_t;

endpackage

// ===== sv/ota_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ota_ctrl
// Sequencer: read, geometry, area, compare for each slot, then a commit.
// ----------------------------------------------------------------------------
module ota_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  output ota_pkg::dp_cmd_t cmd,
  input  ota_pkg::dp_sts_t sts
);
  import ota_pkg::*;

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd = 1'b1;
        state_next = S_GEOM;
      end
      S_GEOM: begin
        cmd.geom = 1'b1;
        state_next = S_AREA;
      end
      S_AREA: begin
        cmd.area = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.cmp = 1'b1;
        cmd.step = 1'b1;
        state_next = sts.last_slot ? S_WRITE : S_READ;
      end
      S_WRITE: begin
        cmd.commit = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ===== sv/ota_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ota_dp
// Track table and overlap datapath: one slot at a time through read,
// geometry, area products and the cross-multiplied compares.
// ----------------------------------------------------------------------------
module ota_dp #(
  parameter int TRACK_SLOTS = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ota_pkg::det_t           det,
  input  logic                    cfg_we,
  input  logic signed [18:0]      cfg_data,
  input  ota_pkg::dp_cmd_t        cmd,
  output ota_pkg::dp_sts_t        sts,
  output ota_pkg::res_t           result,
  output logic                    result_strobe
);
  import ota_pkg::*;

  localparam int IW = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
  localparam int CW = $clog2(TRACK_SLOTS + 1);

  // memory word: class, frame, box, conf, tid, order
  typedef struct packed {
    logic [7:0]         cls;
    logic [23:0]        frame;
    logic signed [15:0] bx;
    logic signed [15:0] by;
    logic [14:0]        bw;
    logic [14:0]        bh;
    logic [15:0]        conf;
    logic [15:0]        tid;
    logic [15:0]        order;
  } slot_t;

  slot_t mem [TRACK_SLOTS];
  slot_t rd_q;
  logic [TRACK_SLOTS-1:0] valid;

  logic signed [18:0] thr;
  det_t d;
  logic [23:0] prev_frame;
  logic [CW-1:0] idx;
  logic [15:0] next_tid, wr_cnt;

  // geometry stage
  logic        g_live, g_cand, g_empty, g_eq;
  logic [16:0] g_iw, g_ih, g_uw, g_uh;
  logic [15:0] g_age;
  // area stage
  logic [33:0] a_num, a_den;
  logic        a_live, a_cand;
  logic [15:0] a_age;
  // best / free
  logic          have_best, have_free;
  logic [IW-1:0] best_idx, free_idx;
  logic [33:0]   b_num, b_den;
  logic [15:0]   b_age;

  always_ff @(posedge clk) begin
    if (rst) thr <= MIN_OVERLAP_RESET;
    else if (cfg_we) thr <= cfg_data;
  end

  assign sts.last_slot = (idx == CW'(TRACK_SLOTS - 1));

  // read
  always_ff @(posedge clk) begin
    if (cmd.rd) rd_q <= mem[idx[IW-1:0]];
  end

  // geometry: extents are 17-bit signed sums
  logic signed [16:0] tx2, ty2, dx2, dy2, ix1, iy1, ix2, iy2, ux1, uy1, ux2, uy2;
  logic signed [17:0] iwd, ihd;
  logic               rvalid;
  always_comb begin
    tx2 = 17'(rd_q.bx) + 17'($signed({1'b0, rd_q.bw}));
    ty2 = 17'(rd_q.by) + 17'($signed({1'b0, rd_q.bh}));
    dx2 = 17'(d.box_x) + 17'($signed({1'b0, d.box_width}));
    dy2 = 17'(d.box_y) + 17'($signed({1'b0, d.box_height}));
    ix1 = (rd_q.bx > d.box_x) ? 17'(rd_q.bx) : 17'(d.box_x);
    iy1 = (rd_q.by > d.box_y) ? 17'(rd_q.by) : 17'(d.box_y);
    ux1 = (rd_q.bx < d.box_x) ? 17'(rd_q.bx) : 17'(d.box_x);
    uy1 = (rd_q.by < d.box_y) ? 17'(rd_q.by) : 17'(d.box_y);
    ix2 = (tx2 < dx2) ? tx2 : dx2;
    iy2 = (ty2 < dy2) ? ty2 : dy2;
    ux2 = (tx2 > dx2) ? tx2 : dx2;
    uy2 = (ty2 > dy2) ? ty2 : dy2;
    iwd = 18'(ix2) - 18'(ix1);
    ihd = 18'(iy2) - 18'(iy1);
    rvalid = valid[idx[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.geom) begin
      g_live  <= rvalid && (rd_q.frame == d.frame_no ||
                 (d.frame_no != '0 && rd_q.frame == prev_frame));
      g_cand  <= rvalid && d.frame_no != '0 && rd_q.frame == prev_frame &&
                 rd_q.cls == d.class_id;
      g_empty <= rd_q.bw == '0 || rd_q.bh == '0 || d.box_width == '0 ||
                 d.box_height == '0;
      g_eq    <= rd_q.bx == d.box_x && rd_q.by == d.box_y &&
                 rd_q.bw == d.box_width && rd_q.bh == d.box_height;
      if (iwd < 0 || ihd < 0) begin
        g_iw <= '0;
        g_ih <= '0;
      end else begin
        g_iw <= iwd[16:0];
        g_ih <= ihd[16:0];
      end
      // union extent is at most 98302, so the 17-bit difference is exact unsigned
      g_uw  <= 17'(ux2 - ux1);
      g_uh  <= 17'(uy2 - uy1);
      g_age <= wr_cnt - rd_q.order;
    end
  end

  // areas
  always_ff @(posedge clk) begin
    if (cmd.area) begin
      a_live  <= g_live;
      a_cand  <= g_cand;
      a_age   <= g_age;
      if (g_empty) begin
        a_num <= g_eq ? 34'd1 : 34'd0;
        a_den <= 34'd1;
      end else begin
        a_num <= 34'(g_iw) * 34'(g_ih);
        a_den <= 34'(g_uw) * 34'(g_uh);
      end
    end
  end

  // compare: threshold and best by cross multiplication
  logic signed [51:0] lhs, rhs;
  logic [67:0] p_new, p_best;
  logic        pass, better;
  always_comb begin
    lhs    = $signed({2'b0, a_num, 16'd0});
    rhs    = 52'(thr) * $signed({18'd0, a_den});
    pass   = !(lhs < rhs);
    p_new  = a_num * b_den;
    p_best = b_num * a_den;
    better = !have_best || p_new > p_best || (p_new == p_best && a_age > b_age);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_best <= 1'b0;
      have_free <= 1'b0;
      idx       <= '0;
    end else if (cmd.load) begin
      have_best <= 1'b0;
      have_free <= 1'b0;
      idx       <= '0;
    end else if (cmd.cmp) begin
      if (!a_live) begin
        if (!have_free) begin
          have_free <= 1'b1;
          free_idx  <= idx[IW-1:0];
        end
      end else if (a_cand && pass && better) begin
        have_best <= 1'b1;
        best_idx  <= idx[IW-1:0];
        b_num     <= a_num;
        b_den     <= a_den;
        b_age     <= a_age;
      end
      if (cmd.step && !sts.last_slot) idx <= idx + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      d          <= det;
      prev_frame <= det.frame_no - 24'd1;
    end
  end

  // commit
  slot_t wr_word, best_word;
  slot_t rd_q_hold;
  always_ff @(posedge clk) begin
    if (cmd.cmp && a_live && a_cand && pass && better) best_word <= rd_q_hold;
  end
  always_ff @(posedge clk) begin
    if (cmd.area) rd_q_hold <= rd_q;
  end

  logic [15:0] ext_conf;
  always_comb begin
    ext_conf = (d.confidence_q16 > best_word.conf) ? d.confidence_q16 : best_word.conf;
    wr_word.cls   = have_best ? best_word.cls : d.class_id;
    wr_word.frame = d.frame_no;
    wr_word.bx    = d.box_x;
    wr_word.by    = d.box_y;
    wr_word.bw    = d.box_width;
    wr_word.bh    = d.box_height;
    wr_word.conf  = have_best ? ext_conf : d.confidence_q16;
    wr_word.tid   = have_best ? best_word.tid : next_tid;
    wr_word.order = wr_cnt;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && (have_best || have_free))
      mem[have_best ? best_idx : free_idx] <= wr_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid         <= '0;
      next_tid      <= '0;
      wr_cnt        <= '0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.commit;
      if (cmd.commit) begin
        if (have_best) begin
          wr_cnt <= wr_cnt + 16'd1;
        end else if (have_free) begin
          valid[free_idx] <= 1'b1;
          wr_cnt   <= wr_cnt + 16'd1;
          next_tid <= next_tid + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (have_best) begin
        result.track_id <= best_word.tid;
        result.status   <= ST_EXTENDED;
        result.track_confidence_q16 <= ext_conf;
      end else if (have_free) begin
        result.track_id <= next_tid;
        result.status   <= ST_NEW;
        result.track_confidence_q16 <= d.confidence_q16;
      end else begin
        result.track_id <= '0;
        result.status   <= ST_FULL;
        result.track_confidence_q16 <= '0;
      end
    end
  end
endmodule

// ===== sv/overlap_track_associator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overlap_track_associator_top
// Greedy overlap tracker: a detection extends or opens a track, or is dropped.
// ----------------------------------------------------------------------------
// Usage: drive det and raise start while busy is low; the word is taken at
// that edge and busy rises the next cycle. The block scans all TRACK_SLOTS
// entries of its track table, each slot through read, box geometry, area
// products and a cross-multiplied compare, then writes back.
// The result word appears on result with result_strobe high for exactly
// one cycle; busy falls with it. A new detection is taken only once the
// previous one is through, since the scan loop steps over the whole table.
// The receiver cannot stall; it must take the result in its strobe cycle.
// The threshold register is to be written with cfg_we/cfg_data only while
// idle; the block itself does not enforce it. Reset (rst, synchronous)
// clears all valid bits, the id and write counters and sets the threshold
// to 0.5; table contents are not cleared.
// ----------------------------------------------------------------------------
module overlap_track_associator_top #(
  parameter int TRACK_SLOTS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  ota_pkg::det_t      det,
  input  logic               cfg_we,
  input  logic signed [18:0] cfg_data,
  output ota_pkg::res_t      result,
  output logic               result_strobe
);
  import ota_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  ota_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .sts(sts)
  );

  ota_dp #(.TRACK_SLOTS(TRACK_SLOTS)) u_dp (
    .clk(clk), .rst(rst), .det(det), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .cmd(cmd), .sts(sts), .result(result), .result_strobe(result_strobe)
  );

  a_strobe_after_commit: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> result_strobe) else $error("result strobe missing");

  a_no_start_while_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !busy) else $error("load while busy");

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> (result.status == ST_EXTENDED || result.status == ST_NEW ||
                       result.status == ST_FULL)) else $error("bad status");

  a_single_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.rd, cmd.geom, cmd.area, cmd.cmp, cmd.commit}))
    else $error("overlapping commands");
endmodule

// ===== verif/overlap_track_associator_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overlap_track_associator_checker
// Watches the detection, config and result channels of the track associator.
// It keeps its own track table to predict each result word, and compares
// every strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
module overlap_track_associator_checker #(
  parameter int TRACK_SLOTS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  ota_pkg::det_t      det,
  input  logic               cfg_we,
  input  logic signed [18:0] cfg_data,
  input  ota_pkg::res_t      result,
  input  logic               result_strobe,
  output int                 errors,
  output int                 pending,
  output int                 n_extended,
  output int                 n_opened,
  output int                 n_dropped
);
  import ota_pkg::*;

  typedef struct {
    bit          valid;
    bit [7:0]    cls;
    bit [23:0]   last_frame;
    longint      bx, by, bw, bh;
    bit [15:0]   conf;
    bit [15:0]   tid;
    bit [15:0]   order;
  } track_t;

  track_t track_tbl[TRACK_SLOTS];
  bit [15:0] next_id;
  bit [15:0] write_count;
  longint    overlap_min;
  res_t      expected_words[$];

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // overlap = num/den; empty boxes are 1 only when identical
  function automatic void box_overlap(input track_t t, input longint x, input longint y,
                                      input longint w, input longint h,
                                      output bit [63:0] num, output bit [63:0] den);
    longint ix1, iy1, ix2, iy2, ux1, uy1, ux2, uy2, iw, ih;
    if (t.bw == 0 || t.bh == 0 || w == 0 || h == 0) begin
      num = (t.bx == x && t.by == y && t.bw == w && t.bh == h) ? 1 : 0;
      den = 1;
      return;
    end
    ix1 = (t.bx > x) ? t.bx : x;
    iy1 = (t.by > y) ? t.by : y;
    ix2 = (t.bx + t.bw < x + w) ? t.bx + t.bw : x + w;
    iy2 = (t.by + t.bh < y + h) ? t.by + t.bh : y + h;
    iw = ix2 - ix1;
    ih = iy2 - iy1;
    if (iw < 0 || ih < 0) begin
      iw = 0;
      ih = 0;
    end
    ux1 = (t.bx < x) ? t.bx : x;
    uy1 = (t.by < y) ? t.by : y;
    ux2 = (t.bx + t.bw > x + w) ? t.bx + t.bw : x + w;
    uy2 = (t.by + t.bh > y + h) ? t.by + t.bh : y + h;
    num = 64'(iw) * 64'(ih);
    den = 64'(ux2 - ux1) * 64'(uy2 - uy1);
  endfunction

  function automatic res_t associate(input det_t d);
    res_t      r;
    bit [23:0] prev_frame;
    longint    x, y, w, h;
    int        best, free_idx;
    bit [63:0] bnum, bden, n, dn;
    bit [15:0] bage, age;
    bit        live;
    prev_frame = d.frame_no - 24'd1;
    x = longint'(d.box_x);
    y = longint'(d.box_y);
    w = longint'(d.box_width);
    h = longint'(d.box_height);
    best = -1;
    free_idx = -1;
    bnum = 0;
    bden = 1;
    bage = 0;
    for (int i = 0; i < TRACK_SLOTS; i++) begin
      live = track_tbl[i].valid && (track_tbl[i].last_frame == d.frame_no ||
             (d.frame_no != 0 && track_tbl[i].last_frame == prev_frame));
      if (!live) begin
        if (free_idx < 0) free_idx = i;
        continue;
      end
      if (d.frame_no == 0 || track_tbl[i].last_frame != prev_frame ||
          track_tbl[i].cls != d.class_id) continue;
      box_overlap(track_tbl[i], x, y, w, h, n, dn);
      if (longint'(n * 64'd65536) < overlap_min * longint'(dn)) continue;
      age = write_count - track_tbl[i].order;
      if (best < 0 || n * bden > bnum * dn || (n * bden == bnum * dn && age > bage)) begin
        best = i;
        bnum = n;
        bden = dn;
        bage = age;
      end
    end
    if (best >= 0) begin
      track_tbl[best].last_frame = d.frame_no;
      track_tbl[best].bx = x;
      track_tbl[best].by = y;
      track_tbl[best].bw = w;
      track_tbl[best].bh = h;
      if (d.confidence_q16 > track_tbl[best].conf) track_tbl[best].conf = d.confidence_q16;
      track_tbl[best].order = write_count;
      write_count++;
      r.track_id = track_tbl[best].tid;
      r.status = ST_EXTENDED;
      r.track_confidence_q16 = track_tbl[best].conf;
    end else if (free_idx >= 0) begin
      track_tbl[free_idx].valid = 1'b1;
      track_tbl[free_idx].cls = d.class_id;
      track_tbl[free_idx].last_frame = d.frame_no;
      track_tbl[free_idx].bx = x;
      track_tbl[free_idx].by = y;
      track_tbl[free_idx].bw = w;
      track_tbl[free_idx].bh = h;
      track_tbl[free_idx].conf = d.confidence_q16;
      track_tbl[free_idx].tid = next_id;
      track_tbl[free_idx].order = write_count;
      next_id++;
      write_count++;
      r.track_id = track_tbl[free_idx].tid;
      r.status = ST_NEW;
      r.track_confidence_q16 = d.confidence_q16;
    end else begin
      r.track_id = '0;
      r.status = ST_FULL;
      r.track_confidence_q16 = '0;
    end
    return r;
  endfunction

  initial begin
    errors = 0;
    n_extended = 0;
    n_opened = 0;
    n_dropped = 0;
  end

  assign pending = expected_words.size();

  always @(posedge clk) begin
    res_t exp_w;
    if (rst) begin
      for (int i = 0; i < TRACK_SLOTS; i++) track_tbl[i].valid = 1'b0;
      next_id = '0;
      write_count = '0;
      overlap_min = longint'(MIN_OVERLAP_RESET);
      expected_words.delete();
    end else begin
      // results are checked before a word taken on the same edge is predicted
      if (result_strobe) begin
        if (expected_words.size() == 0) begin
          report($sformatf("unexpected result id=%0d st=%0d conf=%0d",
                           result.track_id, result.status, result.track_confidence_q16));
        end else begin
          exp_w = expected_words.pop_front();
          if (result.track_id !== exp_w.track_id)
            report($sformatf("track_id got %0d want %0d", result.track_id, exp_w.track_id));
          if (result.status !== exp_w.status)
            report($sformatf("status got %0d want %0d", result.status, exp_w.status));
          if (result.track_confidence_q16 !== exp_w.track_confidence_q16)
            report($sformatf("track_confidence got %0d want %0d",
                             result.track_confidence_q16, exp_w.track_confidence_q16));
          case (exp_w.status)
            ST_EXTENDED: n_extended++;
            ST_NEW:      n_opened++;
            default:     n_dropped++;
          endcase
        end
      end
      if (cfg_we) overlap_min = longint'(cfg_data);
      if (start && !busy) expected_words.insert(expected_words.size(), associate(det));
    end
  end

endmodule

// ===== verif/tb_overlap_track_associator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_overlap_track_associator_top
// Drives detection words into the track associator: a directed opening, then
// phases of moving-object frames with random content, table floods and noise,
// each phase at its own threshold, the sender idling 0, 21 or 70 percent.
// ----------------------------------------------------------------------------
module tb_overlap_track_associator_top;
  import ota_pkg::*;

  localparam int SLOTS = 64;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int MAX_OBJ = 12;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  det_t               det;
  logic               cfg_we;
  logic signed [18:0] cfg_data;
  res_t               result;
  logic               result_strobe;
  int                 errors, pending, n_extended, n_opened, n_dropped;
  int                 cycles;
  int                 idle_pct;
  int                 words_sent;
  bit [23:0]          frame;

  overlap_track_associator_top #(.TRACK_SLOTS(SLOTS)) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .det(det),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .result(result), .result_strobe(result_strobe)
  );

  overlap_track_associator_checker #(.TRACK_SLOTS(SLOTS)) i_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .det(det),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .result(result), .result_strobe(result_strobe),
    .errors(errors), .pending(pending), .n_extended(n_extended), .n_opened(n_opened),
    .n_dropped(n_dropped)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_overlap_track_associator_top failed");
      $finish;
    end
  end

  function automatic det_t mk(input bit [23:0] f, input bit [7:0] c, input int x, input int y,
                              input int w, input int h, input int conf);
    det_t d;
    d.frame_no = f;
    d.class_id = c;
    d.box_x = 16'(x);
    d.box_y = 16'(y);
    d.box_width = 15'(w);
    d.box_height = 15'(h);
    d.confidence_q16 = 16'(conf);
    return d;
  endfunction

  // start stays high across back-to-back words; it only drops for a gap
  task automatic send(input det_t d);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    det <= d;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    words_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_threshold(input logic signed [18:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input int n_words);
    int        n_obj, goal;
    bit [7:0]  ocls[MAX_OBJ];
    int        ox[MAX_OBJ], oy[MAX_OBJ], ow[MAX_OBJ], oh[MAX_OBJ];
    int        sel;
    goal = words_sent + n_words;
    n_obj = $urandom_range(MAX_OBJ, 1);
    for (int k = 0; k < MAX_OBJ; k++) begin
      ocls[k] = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3));
      ox[k] = $urandom_range(65535) - 32768;
      oy[k] = $urandom_range(65535) - 32768;
      sel = $urandom_range(19);
      ow[k] = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(32767) : $urandom_range(200, 4);
      oh[k] = (sel == 2) ? 0 : (sel == 3) ? $urandom_range(32767) : $urandom_range(200, 4);
    end
    while (words_sent < goal) begin
      sel = $urandom_range(99);
      if (sel < 3) frame = 24'($urandom);                // jump, often backwards
      else if (sel < 10) frame = frame + 24'd2;          // skipped frame: tracks go stale
      else frame = frame + 24'd1;
      if ($urandom_range(19) == 0) begin
        // crowded frame fills the table
        for (int k = 0; k < 70 && words_sent < goal; k++)
          send(mk(frame, 8'($urandom_range(255)), $urandom_range(65535) - 32768,
                  $urandom_range(65535) - 32768, $urandom_range(64, 1), $urandom_range(64, 1),
                  $urandom_range(65535)));
        continue;
      end
      for (int k = 0; k < n_obj && words_sent < goal; k++) begin
        if ($urandom_range(9) == 0) continue;           // missed detection
        ox[k] += $urandom_range(12) - 6;
        oy[k] += $urandom_range(12) - 6;
        if (ow[k] != 0 && $urandom_range(3) == 0) ow[k] = $urandom_range(ow[k] + 8, 1) % 32768;
        send(mk(frame, ocls[k], ox[k], oy[k], ow[k], oh[k], $urandom_range(65535)));
        if ($urandom_range(14) == 0)                     // noise word
          send(mk(frame, 8'($urandom), $urandom_range(65535) - 32768,
                  $urandom_range(65535) - 32768, $urandom_range(32767),
                  $urandom_range(32767), $urandom_range(65535)));
      end
      if ($urandom_range(29) == 0) n_obj = $urandom_range(MAX_OBJ, 1);
    end
  endtask

  initial begin
    logic signed [18:0] thresholds[5];
    int                 idles[5];
    thresholds = '{19'sd32768, 19'sd65536, -19'sd131072, 19'sd0, 19'sd131071};
    idles = '{0, 70, 0, 21, 70};
    cycles = 0;
    words_sent = 0;
    idle_pct = 0;
    rst = 1'b1;
    start = 1'b0;
    det = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    frame = 24'd10;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: frame zero, ties, empty boxes, extremes, class mismatch,
    // backward frames and frame wrap
    send(mk(0, 5, 10, 10, 20, 20, 100));
    send(mk(0, 5, 10, 10, 20, 20, 200));
    send(mk(1, 5, 10, 10, 20, 20, 50));
    send(mk(1, 5, 12, 10, 20, 20, 65535));
    send(mk(1, 6, 10, 10, 20, 20, 1));
    send(mk(2, 5, -32768, -32768, 0, 0, 7));
    send(mk(3, 5, -32768, -32768, 0, 0, 9));
    send(mk(3, 5, 32767, 32767, 0, 5, 3));
    send(mk(4, 5, 32767, 32767, 0, 5, 2));
    send(mk(4, 255, -32768, -32768, 32767, 32767, 65535));
    send(mk(5, 255, 32767, 32767, 32767, 32767, 0));
    send(mk(5, 255, 0, 0, 32767, 32767, 1));
    send(mk(2, 5, 10, 10, 20, 20, 5));
    send(mk(24'hFFFFFE, 0, 100, 100, 10, 10, 8));
    send(mk(24'hFFFFFF, 0, 100, 100, 10, 10, 4));
    send(mk(0, 0, 100, 100, 10, 10, 6));
    send(mk(24'h800000, 170, 5, 5, 16384, 8192, 32768));
    send(mk(24'h800001, 170, 6, 5, 16384, 8192, 16384));
    drain();

    for (int p = 0; p < 5; p++) begin
      write_threshold(thresholds[p]);
      idle_pct = idles[p];
      random_phase(140);
      drain();
    end

    start <= 1'b0;
    $display("%0d words sent: %0d extended, %0d new tracks, %0d dropped on a full table;",
             words_sent, n_extended, n_opened, n_dropped);
    $display("thresholds from -2.0 to just under 2.0, sender idle rates 0/21/70 percent");
    if (errors == 0 && pending == 0) begin
      $display("tb_overlap_track_associator_top passed");
    end else begin
      $display("tb_overlap_track_associator_top failed");
    end
    $finish;
  end

endmodule

// ===== overlap_track_associator_top.f =====
sv/ota_pkg.sv
sv/ota_ctrl.sv
sv/ota_dp.sv
sv/overlap_track_associator_top.sv
verif/overlap_track_associator_checker.sv
verif/tb_overlap_track_associator_top.sv
